// ----- hw/rtl/cxalu_pkg.sv -----
package cxalu_pkg;

  // operand and result widths
  localparam int DataW = 32;
  localparam int FracW = 16;
  localparam int ProdW = 2 * DataW;
  localparam int SumW  = ProdW + 1;
  // quotient bits kept by the divider, one above the saturation range
  localparam int QuoW  = DataW + 1;
  localparam int RemW  = SumW + QuoW + 1;

  typedef enum logic [2:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpMul = 3'd2,
    OpDiv = 3'd3,
    OpNeg = 3'd4,
    OpCmp = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [DataW-1:0] a_re;
    logic signed [DataW-1:0] a_im;
    logic signed [DataW-1:0] b_re;
    logic signed [DataW-1:0] b_im;
  } item_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] res_re;
    logic signed [DataW-1:0] res_im;
    logic                    is_equal;
    logic                    div_zero;
    logic                    overflow;
  } item_out_t;

  typedef struct packed {
    logic                    ov;
    logic signed [DataW-1:0] val;
  } sat_t;

  // clamp a wide signed value to the data range
  function automatic sat_t sat_wide(input logic signed [SumW:0] v);
    sat_t r;
    logic signed [SumW:0] hi;
    logic signed [SumW:0] lo;
    hi = (SumW+1)'(signed'({1'b0, {(DataW-1){1'b1}}}));
    lo = -hi - (SumW+1)'(1);
    if (v > hi) begin
      r.ov  = 1'b1;
      r.val = hi[DataW-1:0];
    end else if (v < lo) begin
      r.ov  = 1'b1;
      r.val = lo[DataW-1:0];
    end else begin
      r.ov  = 1'b0;
      r.val = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/cxalu_div.sv -----
module cxalu_div (
  input  logic                        clk_i,
  input  logic [cxalu_pkg::SumW-1:0]  num_i,
  input  logic [cxalu_pkg::SumW-1:0]  den_i,
  output logic [cxalu_pkg::QuoW-1:0]  quo_o,
  output logic                        big_o
);
  import cxalu_pkg::*;

  logic [RemW-1:0] rem_q [0:QuoW];
  logic [RemW-1:0] den_q [0:QuoW];
  logic [QuoW-1:0] quo_q [0:QuoW];
  logic            big_q [0:QuoW];
  logic [RemW-1:0] dividend;

  assign dividend = RemW'({num_i, {FracW{1'b0}}});

  // entry stage: scaled dividend and quotient range check
  always_ff @(posedge clk_i) begin
    rem_q[0] <= dividend;
    den_q[0] <= RemW'(den_i);
    quo_q[0] <= '0;
    big_q[0] <= dividend >= (RemW'(den_i) << QuoW);
  end

  // one restoring step per stage, msb of the quotient first
  for (genvar j = 1; j <= QuoW; j++) begin : g_step
    localparam int Sh = QuoW - j;
    logic [RemW:0] diff;
    assign diff = {1'b0, rem_q[j-1]} - {1'b0, den_q[j-1] << Sh};
    always_ff @(posedge clk_i) begin
      rem_q[j] <= diff[RemW] ? rem_q[j-1] : diff[RemW-1:0];
      quo_q[j] <= {quo_q[j-1][QuoW-2:0], ~diff[RemW]};
      den_q[j] <= den_q[j-1];
      big_q[j] <= big_q[j-1];
    end
  end

  assign quo_o = quo_q[QuoW];
  assign big_o = big_q[QuoW];

endmodule

// ----- hw/rtl/complex_arith_alu_unit.sv -----
// complex arithmetic unit, signed Q16.16 operands and results
// input channel: item_i is taken at a rising edge with start_i high and busy_o
// low; busy_o stays low, so an item may be started in every cycle
// output channel: each result shows on result_o for exactly one cycle with
// valid_o high; there is no back-pressure and results come out in order
// every opcode runs through one product stage, one sum stage,
// 34 stages of the restoring divider (range check plus 33 quotient bits,
// one bit per stage) and the output register; all opcodes share that path
// throughput is one item per cycle
// flags: overflow when a part saturated, div_zero for a zero divisor (result
// zero), is_equal for the compare opcode
// reset clears the valid bits only; items in flight at reset are dropped
module complex_arith_alu_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  cxalu_pkg::item_in_t   item_i,
  output logic                  valid_o,
  output cxalu_pkg::item_out_t  result_o
);
  import cxalu_pkg::*;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
    logic                    ov;
    logic                    eq;
    logic                    dz;
    logic                    neg_re;
    logic                    neg_im;
  } mid_t;

  assign busy_o = 1'b0;

  // stage 1: products, the divide-by-zero check and the add, subtract, negate and compare ops
  logic                    v1_q;
  op_e                     op1_q;
  logic signed [ProdW-1:0] rr_q, ii_q, ri_q, ir_q, br2_q, bi2_q;
  sat_t                    sre1_d, sim1_d, sre1_q, sim1_q;
  logic                    eq1_d, eq1_q, dz1_q;

  always_comb begin
    sre1_d = '0;
    sim1_d = '0;
    eq1_d  = 1'b0;
    case (item_i.opcode)
      OpAdd: begin
        sre1_d = sat_wide((SumW+1)'(item_i.a_re) + (SumW+1)'(item_i.b_re));
        sim1_d = sat_wide((SumW+1)'(item_i.a_im) + (SumW+1)'(item_i.b_im));
      end
      OpSub: begin
        sre1_d = sat_wide((SumW+1)'(item_i.a_re) - (SumW+1)'(item_i.b_re));
        sim1_d = sat_wide((SumW+1)'(item_i.a_im) - (SumW+1)'(item_i.b_im));
      end
      OpNeg: begin
        sre1_d = sat_wide(-(SumW+1)'(item_i.a_re));
        sim1_d = sat_wide(-(SumW+1)'(item_i.a_im));
      end
      OpCmp: begin
        eq1_d = (item_i.a_re == item_i.b_re) && (item_i.a_im == item_i.b_im);
      end
      default: begin
        eq1_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= op_e'(item_i.opcode);
    rr_q   <= item_i.a_re * item_i.b_re;
    ii_q   <= item_i.a_im * item_i.b_im;
    ri_q   <= item_i.a_re * item_i.b_im;
    ir_q   <= item_i.a_im * item_i.b_re;
    br2_q  <= item_i.b_re * item_i.b_re;
    bi2_q  <= item_i.b_im * item_i.b_im;
    sre1_q <= sre1_d;
    sim1_q <= sim1_d;
    eq1_q  <= eq1_d;
    dz1_q  <= (item_i.b_re == '0) && (item_i.b_im == '0);
  end

  // stage 2: sums of products and squared divisor magnitude
  logic                   v2_q;
  op_e                    op2_q;
  logic signed [SumW-1:0] sre2_q, sim2_q;
  logic [SumW-1:0]        den2_q;
  sat_t                   sre2_sq, sim2_sq;
  logic                   eq2_q, dz2_q;

  always_ff @(posedge clk_i) begin
    op2_q   <= op1_q;
    if (op1_q == OpMul) begin
      sre2_q <= SumW'(rr_q) - SumW'(ii_q);
      sim2_q <= SumW'(ri_q) + SumW'(ir_q);
    end else begin
      sre2_q <= SumW'(rr_q) + SumW'(ii_q);
      sim2_q <= SumW'(ir_q) - SumW'(ri_q);
    end
    den2_q  <= SumW'(br2_q) + SumW'(bi2_q);
    sre2_sq <= sre1_q;
    sim2_sq <= sim1_q;
    eq2_q   <= eq1_q;
    dz2_q   <= dz1_q;
  end

  // stage 3: product scaling with truncation toward zero, divider operands
  logic signed [SumW:0] mre_sh, mim_sh;
  logic [SumW-1:0]      mag_re, mag_im;
  sat_t                 mre_s, mim_s;
  mid_t                 mid_d;

  always_comb begin
    mre_sh = ((SumW+1)'(sre2_q) +
              (sre2_q[SumW-1] ? (SumW+1)'((1 << FracW) - 1) : (SumW+1)'(0))) >>> FracW;
    mim_sh = ((SumW+1)'(sim2_q) +
              (sim2_q[SumW-1] ? (SumW+1)'((1 << FracW) - 1) : (SumW+1)'(0))) >>> FracW;
    mre_s  = sat_wide(mre_sh);
    mim_s  = sat_wide(mim_sh);
    mag_re = sre2_q[SumW-1] ? SumW'(-sre2_q) : SumW'(sre2_q);
    mag_im = sim2_q[SumW-1] ? SumW'(-sim2_q) : SumW'(sim2_q);
    mid_d.op     = op2_q;
    mid_d.re     = (op2_q == OpMul) ? mre_s.val : sre2_sq.val;
    mid_d.im     = (op2_q == OpMul) ? mim_s.val : sim2_sq.val;
    mid_d.ov     = (op2_q == OpMul) ? (mre_s.ov | mim_s.ov) : (sre2_sq.ov | sim2_sq.ov);
    mid_d.eq     = eq2_q;
    mid_d.dz     = dz2_q;
    mid_d.neg_re = sre2_q[SumW-1];
    mid_d.neg_im = sim2_q[SumW-1];
  end

  logic [QuoW-1:0] quo_re, quo_im;
  logic            big_re, big_im;

  cxalu_div u_div_re (
    .clk_i (clk_i),
    .num_i (mag_re),
    .den_i (den2_q),
    .quo_o (quo_re),
    .big_o (big_re)
  );

  cxalu_div u_div_im (
    .clk_i (clk_i),
    .num_i (mag_im),
    .den_i (den2_q),
    .quo_o (quo_im),
    .big_o (big_im)
  );

  // side line that keeps item data aligned with the divider
  mid_t mid_q [0:QuoW];
  logic vl_q  [0:QuoW];

  always_ff @(posedge clk_i) begin
    mid_q[0] <= mid_d;
  end

  for (genvar j = 1; j <= QuoW; j++) begin : g_line
    always_ff @(posedge clk_i) begin
      mid_q[j] <= mid_q[j-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vl_q[j] <= 1'b0;
      end else begin
        vl_q[j] <= vl_q[j-1];
      end
    end
  end

  // valid bits of the front stages and of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      vl_q[0] <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= start_i && !busy_o;
      v2_q    <= v1_q;
      vl_q[0] <= v2_q;
      valid_o <= vl_q[QuoW];
    end
  end

  // final stage: signed, saturated quotients and result select
  sat_t      dre_s, dim_s;
  item_out_t res_d;
  mid_t      mid_l;

  function automatic sat_t sat_quo(input logic [QuoW-1:0] q, input logic big,
                                   input logic neg);
    sat_t r;
    logic [QuoW-1:0] lim;
    lim = QuoW'(1) << (DataW - 1);
    if (neg) begin
      r.ov  = big || (q > lim);
      r.val = r.ov ? DataW'(lim) : DataW'(-q);
    end else begin
      r.ov  = big || (q >= lim);
      r.val = r.ov ? DataW'(lim - QuoW'(1)) : DataW'(q);
    end
    return r;
  endfunction

  always_comb begin
    mid_l = mid_q[QuoW];
    dre_s = sat_quo(quo_re, big_re, mid_l.neg_re);
    dim_s = sat_quo(quo_im, big_im, mid_l.neg_im);
    res_d = '0;
    case (mid_l.op)
      OpAdd, OpSub, OpMul, OpNeg: begin
        res_d.res_re   = mid_l.re;
        res_d.res_im   = mid_l.im;
        res_d.overflow = mid_l.ov;
      end
      OpDiv: begin
        if (mid_l.dz) begin
          res_d.div_zero = 1'b1;
        end else begin
          res_d.res_re   = dre_s.val;
          res_d.res_im   = dim_s.val;
          res_d.overflow = dre_s.ov | dim_s.ov;
        end
      end
      OpCmp: begin
        res_d.is_equal = mid_l.eq;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_d;
  end

  // checks
  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.div_zero |->
      !result_o.overflow && result_o.res_re == '0 && result_o.res_im == '0)
    else $error("divide by zero result not clean");

  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.is_equal |->
      !result_o.div_zero && !result_o.overflow && result_o.res_re == '0)
    else $error("compare result carries other fields");

  a_line_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vl_q[QuoW] |=> valid_o)
    else $error("result strobe lost at output stage");

endmodule
